@@ hdl/cabe_pkg.sv @@
package cabe_pkg;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_ADC = 4'd1,
      OP_SBC = 4'd2,
      OP_CLC = 4'd3,
      OP_CLD = 4'd4,
      OP_CLI = 4'd5,
      OP_CLV = 4'd6,
      OP_BCC = 4'd7,
      OP_BCS = 4'd8,
      OP_BEQ = 4'd9,
      OP_BNE = 4'd10,
      OP_BMI = 4'd11,
      OP_BPL = 4'd12,
      OP_BVC = 4'd13,
      OP_BVS = 4'd14
   } op_type;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [1:0] EXTRA_NONE  = 2'd0;
   localparam logic [1:0] EXTRA_TAKEN = 2'd1;
   localparam logic [1:0] EXTRA_PAGE  = 2'd2;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  status;
      logic [15:0] pc;
      logic        taken;
      logic [1:0]  extra;
   } exec_result_type;

endpackage

@@ hdl/cabe_exec.sv @@
module cabe_exec
   import cabe_pkg::*;
(
   input  logic [3:0]        op,
   input  logic [7:0]        operand,
   input  logic signed [7:0] offset,
   input  logic [15:0]       pc,
   input  logic [7:0]        acc,
   input  logic [7:0]        status,
   output exec_result_type   result
);

   logic [7:0]  addend;
   logic [8:0]  sum;
   logic [7:0]  and_res;
   logic [15:0] target;
   logic        is_branch;
   logic        cond;

   always_comb begin
      addend  = (op == OP_SBC) ? ~operand : operand;
      sum     = {1'b0, acc} + {1'b0, addend} + {8'd0, status[FLAG_C]};
      and_res = acc & operand;
      target  = pc + {{8{offset[7]}}, offset};

      result.acc    = acc;
      result.status = status;
      is_branch     = 1'b0;
      cond          = 1'b0;

      unique case (op)
         OP_AND: begin
            result.acc            = and_res;
            result.status[FLAG_Z] = (and_res == 8'd0);
            result.status[FLAG_N] = and_res[7];
         end
         OP_ADC, OP_SBC: begin
            result.acc            = sum[7:0];
            result.status[FLAG_C] = sum[8];
            result.status[FLAG_Z] = (sum[7:0] == 8'd0);
            result.status[FLAG_N] = sum[7];
            result.status[FLAG_V] = (sum[7] ^ acc[7]) & (sum[7] ^ addend[7]);
         end
         OP_CLC: result.status[FLAG_C] = 1'b0;
         OP_CLD: result.status[FLAG_D] = 1'b0;
         OP_CLI: result.status[FLAG_I] = 1'b0;
         OP_CLV: result.status[FLAG_V] = 1'b0;
         OP_BCC: begin
            is_branch = 1'b1;
            cond      = ~status[FLAG_C];
         end
         OP_BCS: begin
            is_branch = 1'b1;
            cond      = status[FLAG_C];
         end
         OP_BEQ: begin
            is_branch = 1'b1;
            cond      = status[FLAG_Z];
         end
         OP_BNE: begin
            is_branch = 1'b1;
            cond      = ~status[FLAG_Z];
         end
         OP_BMI: begin
            is_branch = 1'b1;
            cond      = status[FLAG_N];
         end
         OP_BPL: begin
            is_branch = 1'b1;
            cond      = ~status[FLAG_N];
         end
         OP_BVC: begin
            is_branch = 1'b1;
            cond      = ~status[FLAG_V];
         end
         OP_BVS: begin
            is_branch = 1'b1;
            cond      = status[FLAG_V];
         end
         default: begin
         end
      endcase

      result.taken = is_branch & cond;
      if (result.taken) begin
         result.pc    = target;
         result.extra = (target[15:8] != pc[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
      end else begin
         result.pc    = pc;
         result.extra = EXTRA_NONE;
      end
   end

endmodule

@@ hdl/cpu6502_alu_branch_execute_top.sv @@
// Execute stage for a 6502 subset: AND, binary ADC/SBC, CLC/CLD/CLI/CLV and
// the eight conditional relative branches. Accumulator and status live here.
//
// Request channel (req_*): op, operand byte, signed offset, pc after fetch.
// Response channel (rsp_*): new accumulator, new status, next pc, taken flag,
// extra cycles (1 when taken, 2 when the target crosses a 256-byte page).
// Both channels use valid/ready; a transfer occurs when both are high.
//
// A request accepted into the input register is executed and registered into
// the response register, raising rsp_valid, once it is empty or being drained.
// Throughput: one request per cycle while rsp_ready is high, via one input
// register, the 8-bit ALU and 16-bit branch adder and the response register.
//
// The request register keeps accepting while a response waits as long as the
// response register will be freed; when rsp_ready is low and both stages are
// full, req_ready drops and everything holds, state included.
// Reset clears accumulator, status and both valid bits.
module cpu6502_alu_branch_execute_top
   import cabe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_op,
   input  logic [7:0]         req_operand,
   input  logic signed [7:0]  req_offset,
   input  logic [15:0]        req_pc_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_acc_out,
   output logic [7:0]         rsp_status_out,
   output logic [15:0]        rsp_pc_out,
   output logic               rsp_branch_taken,
   output logic [1:0]         rsp_extra_cycles
);

   logic              in_valid_ff, in_valid_in;
   logic [3:0]        op_ff;
   logic [7:0]        operand_ff;
   logic signed [7:0] offset_ff;
   logic [15:0]       pc_ff;
   logic              out_valid_ff, out_valid_in;
   exec_result_type   out_ff;
   logic [7:0]        acc_ff, acc_in;
   logic [7:0]        status_ff, status_in;
   exec_result_type   exec_res;
   logic              advance;
   logic              req_take;

   cabe_exec u_exec (
      .op      (op_ff),
      .operand (operand_ff),
      .offset  (offset_ff),
      .pc      (pc_ff),
      .acc     (acc_ff),
      .status  (status_ff),
      .result  (exec_res)
   );

   always_comb begin
      advance      = in_valid_ff & (~out_valid_ff | rsp_ready);
      req_ready    = ~in_valid_ff | advance;
      req_take     = req_valid & req_ready;
      in_valid_in  = req_take | (in_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & ~rsp_ready);
      acc_in       = advance ? exec_res.acc : acc_ff;
      status_in    = advance ? exec_res.status : status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         status_ff    <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= req_op;
         operand_ff <= req_operand;
         offset_ff  <= req_offset;
         pc_ff      <= req_pc_in;
      end
      if (advance) begin
         out_ff <= exec_res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_acc_out      = out_ff.acc;
   assign rsp_status_out   = out_ff.status;
   assign rsp_pc_out       = out_ff.pc;
   assign rsp_branch_taken = out_ff.taken;
   assign rsp_extra_cycles = out_ff.extra;

   a_taken_extra: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.taken == (out_ff.extra != EXTRA_NONE)))
      else $error("taken flag and extra cycles disagree");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("response register not loaded after advance");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(acc_ff) && $stable(status_ff)))
      else $error("state changed without an executed request");

   a_stall_holds_req: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("pending request lost during stall");

   a_response_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_ff.acc == acc_ff && out_ff.status == status_ff))
      else $error("response and architectural state diverge");

endmodule
